[sv/mep_pkg.sv]
// mep_pkg: shared types, register indexes and small helpers for the escape-time pixel block
// no dependencies
`timescale 1ns / 1ps

package mep_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgWidthLog2  = 2'd0;
  localparam logic [1:0] CfgHeightLog2 = 2'd1;
  localparam logic [1:0] CfgMaxIter    = 2'd2;

  localparam logic [3:0] WidthLog2Rst  = 4'd8;
  localparam logic [3:0] HeightLog2Rst = 4'd8;
  localparam logic [7:0] MaxIterRst    = 8'd64;

  // largest supported image side, as log2
  localparam logic [3:0] MaxSizeLog2   = 4'd12;

  localparam logic [7:0] AlphaOpaque   = 8'hFF;

  typedef enum logic [1:0] {
    StIdle,
    StMulSx,
    StMulSy,
    StMulXy
  } state_e;

  // size register clamped to 1 .. MaxSizeLog2
  function automatic logic [3:0] clamp_log2(input logic [3:0] v);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > MaxSizeLog2) begin
      r = MaxSizeLog2;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // palette: black inside the set, otherwise a ramp on the count
  function automatic logic [31:0] escape_color(input logic [7:0] n, input logic inside_set);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [31:0] c;
    r = n * 8'd30;
    g = {n[5:0], 2'b00};
    b = ~r;
    if (inside_set) begin
      c = {AlphaOpaque, 24'h000000};
    end else begin
      c = {AlphaOpaque, r, g, b};
    end
    return c;
  endfunction

endpackage

[sv/mep_mul.sv]
// mep_mul: shared signed fixed-point multiplier, magnitude truncated toward zero
// uses no package; operands must stay stable from start until done
`timescale 1ns / 1ps

module mep_mul #(
  parameter int OP_W      = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [OP_W-1:0]                    a_i,
  input  logic signed [OP_W-1:0]                    b_i,
  output logic                                      done_o,
  output logic signed [2*(OP_W-1)-FRAC_BITS:0]      p_o
);

  localparam int MAG_W    = OP_W - 1;
  localparam int NUM_PASS = (MAG_W + 31) / 32;
  localparam int SLICE_W  = (MAG_W + NUM_PASS - 1) / NUM_PASS;
  localparam int PAD_W    = NUM_PASS * SLICE_W;
  localparam int ACC_W    = MAG_W + PAD_W;
  localparam int P_W      = 2 * MAG_W - FRAC_BITS + 1;
  localparam int PASS_W   = (NUM_PASS > 1) ? $clog2(NUM_PASS) : 1;
  localparam int PROD_W   = MAG_W + SLICE_W;

  logic [OP_W-1:0]    a_abs;
  logic [OP_W-1:0]    b_abs;
  logic [MAG_W-1:0]   a_mag;
  logic [PAD_W-1:0]   b_pad;
  logic [PASS_W-1:0]  pass_sel;
  logic [SLICE_W-1:0] b_slice;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   part;
  logic [ACC_W-1:0]   acc_d, acc_q;
  logic [PASS_W-1:0]  pass_q;
  logic               run_q, fin_q, done_q;
  logic [P_W-1:0]     mag_ext;
  logic signed [P_W-1:0] p_d, p_q;

  assign a_abs    = a_i[OP_W-1] ? OP_W'(-a_i) : a_i;
  assign b_abs    = b_i[OP_W-1] ? OP_W'(-b_i) : b_i;
  assign a_mag    = a_abs[MAG_W-1:0];
  assign b_pad    = PAD_W'(b_abs[MAG_W-1:0]);
  assign pass_sel = start_i ? '0 : pass_q;
  assign b_slice  = b_pad[pass_sel*SLICE_W +: SLICE_W];
  assign prod     = PROD_W'(a_mag) * PROD_W'(b_slice);
  assign part     = ACC_W'(prod) << (pass_sel * SLICE_W);
  assign acc_d    = (start_i ? '0 : acc_q) + part;

  // shift out the fraction, then restore the sign
  assign mag_ext  = {1'b0, acc_q[2*MAG_W-1:FRAC_BITS]};
  assign p_d      = (a_i[OP_W-1] ^ b_i[OP_W-1]) ? $signed(-mag_ext) : $signed(mag_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      if (start_i) begin
        pass_q <= PASS_W'(1);
        run_q  <= (NUM_PASS > 1);
        fin_q  <= (NUM_PASS == 1);
      end else if (run_q) begin
        pass_q <= pass_q + PASS_W'(1);
        if (pass_q == PASS_W'(NUM_PASS - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i || run_q) begin
      acc_q <= acc_d;
    end
    if (fin_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

[sv/mandelbrot_escape_pixel_top.sv]
// mandelbrot_escape_pixel_top: escape-time evaluator, one pixel per request; uses mep_pkg, mep_mul
// each step is three products on the shared multiplier, two on the last step (slower above
//   29 fraction bits); a zero iteration limit strobes in the cycle after the request is taken
// throughput: one request in flight, the next one is taken in the strobe cycle; no receiver stall
// reset: asynchronous, active low; registers return to 8 / 8 / 64, sequencer idle
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_top #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  // result
  output logic        done_o,
  output logic [7:0]  escape_count_o,
  output logic        in_set_o,
  output logic [31:0] color_argb_o
);

  // z stays below 6.5 in magnitude, so three integer bits plus sign suffice
  localparam int Z_W  = FRAC_BITS + 4;
  // products reach about 42, sums about 84
  localparam int P_W  = 2 * (Z_W - 1) - FRAC_BITS + 1;
  localparam int SH_W = FRAC_BITS + 14;

  localparam logic signed [Z_W-1:0] TwoQ       = {2'b00, 2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [Z_W-1:0] OneHalfQ   = {3'b000, 2'b11, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [P_W:0]   EscapeBound = {{(P_W-FRAC_BITS-2){1'b0}}, 3'b100,
                                                   {FRAC_BITS{1'b0}}};

  // configuration registers
  logic [3:0] width_log2_q, height_log2_q;
  logic [7:0] max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= mep_pkg::WidthLog2Rst;
      height_log2_q <= mep_pkg::HeightLog2Rst;
      max_iter_q    <= mep_pkg::MaxIterRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mep_pkg::CfgWidthLog2:  width_log2_q  <= cfg_data_i[3:0];
        mep_pkg::CfgHeightLog2: height_log2_q <= cfg_data_i[3:0];
        mep_pkg::CfgMaxIter:    max_iter_q    <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pixel to c mapping: 3*p scaled by 2^(FRAC_BITS - log2 size), minus the window origin
  logic [3:0]  lg_x, lg_y;
  logic [11:0] px_m, py_m;
  logic [13:0] tri_x, tri_y;
  logic [SH_W-1:0] sc_x, sc_y;
  logic signed [Z_W-1:0] cx_map, cy_map;

  assign lg_x   = mep_pkg::clamp_log2(width_log2_q);
  assign lg_y   = mep_pkg::clamp_log2(height_log2_q);
  // bits at or above the size are ignored
  assign px_m   = pixel_x_i & ~(12'hFFF << lg_x);
  assign py_m   = pixel_y_i & ~(12'hFFF << lg_y);
  assign tri_x  = {2'b00, px_m} + {1'b0, px_m, 1'b0};
  assign tri_y  = {2'b00, py_m} + {1'b0, py_m, 1'b0};
  // exact: the masked coordinate is below 2^lg, so no bits fall off
  assign sc_x   = {tri_x, {FRAC_BITS{1'b0}}} >> lg_x;
  assign sc_y   = {tri_y, {FRAC_BITS{1'b0}}} >> lg_y;
  assign cx_map = $signed(sc_x[Z_W-1:0]) - TwoQ;
  assign cy_map = $signed(sc_y[Z_W-1:0]) - OneHalfQ;

  // sequencer and datapath
  mep_pkg::state_e state_q, state_d;

  logic accept;
  logic signed [Z_W-1:0] cx_q, cy_q, zx_q, zy_q;
  logic signed [P_W-1:0] sx_q, sy_q;
  logic [7:0]  iter_q;
  logic        issued_q;
  logic        mul_start, mul_done;
  logic signed [Z_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0] mul_p;
  logic signed [P_W:0]   mag_sum, zx_sum, zy_sum;
  logic        escaped, last_iter;

  logic        done_q, in_set_q;
  logic [7:0]  count_q;
  logic [31:0] color_q;

  assign accept    = start && (state_q == mep_pkg::StIdle);
  assign busy      = (state_q != mep_pkg::StIdle);

  // |z|^2 test uses the square just finished together with the stored one
  assign mag_sum   = (P_W+1)'(sx_q) + (P_W+1)'(mul_p);
  assign escaped   = (mag_sum > EscapeBound);
  assign last_iter = (iter_q == max_iter_q - 8'd1);

  // next z, formed when the cross product lands
  assign zx_sum    = (P_W+1)'(sx_q) - (P_W+1)'(sy_q) + (P_W+1)'(cx_q);
  assign zy_sum    = {mul_p, 1'b0} + (P_W+1)'(cy_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mep_pkg::StIdle: begin
        if (accept && (max_iter_q != 8'd0)) begin
          state_d = mep_pkg::StMulSx;
        end
      end
      mep_pkg::StMulSx: begin
        if (mul_done) begin
          state_d = mep_pkg::StMulSy;
        end
      end
      mep_pkg::StMulSy: begin
        if (mul_done) begin
          state_d = (escaped || last_iter) ? mep_pkg::StIdle : mep_pkg::StMulXy;
        end
      end
      mep_pkg::StMulXy: begin
        if (mul_done) begin
          state_d = mep_pkg::StMulSx;
        end
      end
      default: state_d = mep_pkg::StIdle;
    endcase
  end

  // operand select and a single start per product
  always_comb begin
    mul_start = 1'b0;
    mul_a     = zx_q;
    mul_b     = zx_q;
    case (state_q)
      mep_pkg::StMulSx: begin
        mul_start = !issued_q;
      end
      mep_pkg::StMulSy: begin
        mul_start = !issued_q;
        mul_a     = zy_q;
        mul_b     = zy_q;
      end
      mep_pkg::StMulXy: begin
        mul_start = !issued_q;
        mul_b     = zy_q;
      end
      default: mul_start = 1'b0;
    endcase
  end

  mep_mul #(
    .OP_W      (Z_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mep_pkg::StIdle;
      issued_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_done) begin
        issued_q <= 1'b0;
      end else if (mul_start) begin
        issued_q <= 1'b1;
      end
      done_q <= (accept && (max_iter_q == 8'd0))
             || ((state_q == mep_pkg::StMulSy) && mul_done && (escaped || last_iter));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      // z starts at zero, so the first update leaves z = c
      cx_q   <= cx_map;
      cy_q   <= cy_map;
      zx_q   <= cx_map;
      zy_q   <= cy_map;
      iter_q <= 8'd0;
      if (max_iter_q == 8'd0) begin
        count_q  <= 8'd0;
        in_set_q <= 1'b1;
        color_q  <= mep_pkg::escape_color(8'd0, 1'b1);
      end
    end
    if (mul_done) begin
      case (state_q)
        mep_pkg::StMulSx: sx_q <= mul_p;
        mep_pkg::StMulSy: begin
          sy_q <= mul_p;
          if (escaped) begin
            count_q  <= iter_q;
            in_set_q <= 1'b0;
            color_q  <= mep_pkg::escape_color(iter_q, 1'b0);
          end else if (last_iter) begin
            count_q  <= max_iter_q;
            in_set_q <= 1'b1;
            color_q  <= mep_pkg::escape_color(max_iter_q, 1'b1);
          end else begin
            iter_q <= iter_q + 8'd1;
          end
        end
        mep_pkg::StMulXy: begin
          zx_q <= zx_sum[Z_W-1:0];
          zy_q <= zy_sum[Z_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign done_o         = done_q;
  assign escape_count_o = count_q;
  assign in_set_o       = in_set_q;
  assign color_argb_o   = color_q;

endmodule

[test/tb_mandelbrot_escape_pixel_top.sv]
// tb_mandelbrot_escape_pixel_top: self-checking bench for the escape-time pixel block,
// random and directed pixel requests checked against a fixed-point escape-time predictor
// depends on mep_pkg and mandelbrot_escape_pixel_top
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel_top;

  localparam int FracBits = 28;
  // the slowest correct run ends well under this hang guard limit
  localparam int unsigned CycleLimit = 4_000_000;

  // corners, masked-off coordinate bits, points on the real axis inside the set,
  // the cusp at c = -2 (|z|^2 lands exactly on 4) and alternating bit patterns
  localparam logic [23:0] DirectedPixels [20] = '{
    {12'd0,    12'd0},    {12'hFFF, 12'hFFF}, {12'd0,    12'hFFF}, {12'hFFF, 12'd0},
    {12'd255,  12'd255},  {12'd171, 12'd128}, {12'd85,   12'd128}, {12'd43,  12'd128},
    {12'd64,   12'd128},  {12'd0,   12'd128}, {12'd128,  12'd128}, {12'd192, 12'd0},
    {12'd213,  12'd128},  {12'd200, 12'd200}, {12'd256,  12'd0},   {12'h800, 12'h400},
    {12'hAAA,  12'h555},  {12'h555, 12'hAAA}, {12'd150,  12'd90},  {12'd110, 12'd165}
  };

  typedef struct packed {
    logic [7:0]  count;
    logic        in_set;
    logic [31:0] color;
  } pixel_result_t;

  // holds a shadow of the size and limit registers, predicts each pixel on
  // request and compares the strobed results in order
  class escape_scoreboard;
    logic [3:0]    width_log2;
    logic [3:0]    height_log2;
    logic [7:0]    iter_limit;
    pixel_result_t expected_pixels[$];
    int            errors;

    function new();
      width_log2  = mep_pkg::WidthLog2Rst;
      height_log2 = mep_pkg::HeightLog2Rst;
      iter_limit  = mep_pkg::MaxIterRst;
      errors      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
        mep_pkg::CfgWidthLog2:  width_log2  = data[3:0];
        mep_pkg::CfgHeightLog2: height_log2 = data[3:0];
        mep_pkg::CfgMaxIter:    iter_limit  = data;
        default: ;
      endcase
    endfunction

    function int size_log2(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > mep_pkg::MaxSizeLog2) return int'(mep_pkg::MaxSizeLog2);
      return int'(v);
    endfunction

    // signed fixed-point product, magnitude truncated toward zero
    function longint fx_product(longint a, longint b);
      logic         neg;
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  mag;
      logic [127:0] full;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? 64'(-a) : 64'(a);
      ub   = (b < 0) ? 64'(-b) : 64'(b);
      full = {64'd0, ua} * {64'd0, ub};
      mag  = 64'(full >> FracBits);
      mag[63] = 1'b0;
      return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function pixel_result_t escape_time_of(logic [11:0] px, logic [11:0] py);
      longint        one;
      longint        cx;
      longint        cy;
      longint        zx;
      longint        zy;
      longint        nx;
      longint        ny;
      longint        mx;
      longint        my;
      int            lw;
      int            lh;
      int            n;
      pixel_result_t r;
      one = 64'sd1 <<< FracBits;
      lw  = size_log2(width_log2);
      lh  = size_log2(height_log2);
      mx  = longint'(px) & ((64'sd1 <<< lw) - 1);
      my  = longint'(py) & ((64'sd1 <<< lh) - 1);
      cx  = ((3 * mx) <<< (FracBits - lw)) - 2 * one;
      cy  = ((3 * my) <<< (FracBits - lh)) - (one + one / 2);
      zx  = 0;
      zy  = 0;
      n   = int'(iter_limit);
      for (int i = 0; i < int'(iter_limit); i++) begin
        nx = fx_product(zx, zx) - fx_product(zy, zy) + cx;
        ny = 2 * fx_product(zx, zy) + cy;
        zx = nx;
        zy = ny;
        if (fx_product(zx, zx) + fx_product(zy, zy) > 4 * one) begin
          n = i;
          break;
        end
      end
      r.count  = n[7:0];
      r.in_set = (n == int'(iter_limit));
      if (r.in_set) begin
        r.color = 32'hFF00_0000;
      end else begin
        r.color = {8'hFF, 8'(30 * n), 8'(4 * n), 8'(255 - 30 * n)};
      end
      return r;
    endfunction

    function void note_request(logic [11:0] px, logic [11:0] py);
      expected_pixels.push_back(escape_time_of(px, py));
    endfunction

    function void check_result(logic [7:0] count, logic in_set, logic [31:0] color);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("escape_count result with no request pending: %0d", count);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (count !== e.count) begin
        $error("escape_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
      if (in_set !== e.in_set) begin
        $error("in_set: expected %0b, actual %0b", e.in_set, in_set);
        errors++;
      end
      if (color !== e.color) begin
        $error("color_argb: expected %08h, actual %08h", e.color, color);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        start;
  logic        busy;
  logic [11:0] pixel_x_i;
  logic [11:0] pixel_y_i;
  logic        done_o;
  logic [7:0]  escape_count_o;
  logic        in_set_o;
  logic [31:0] color_argb_o;

  int unsigned      cycle_count = 0;
  escape_scoreboard sb;

  mandelbrot_escape_pixel_top #(
    .FRAC_BITS(FracBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .done_o         (done_o),
    .escape_count_o (escape_count_o),
    .in_set_o       (in_set_o),
    .color_argb_o   (color_argb_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // results last one cycle and cannot be held off, so sample every edge;
  // values read here are the ones held during the cycle the edge closes
  always @(posedge clk_i) begin
    if (done_o === 1'b1) begin
      sb.check_result(escape_count_o, in_set_o, color_argb_o);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request; entered just after an edge, returns just after the accepting edge
  // with start still high so a back-to-back request needs no second assignment
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(px, py);
  endtask

  // block idle: every predicted result has come back
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // every request yields a result, so only a short settle is needed
    repeat (4) @(posedge clk_i);
  endtask

  // size registers get random upper bits, which the block must drop;
  // the unused index is written too and must change nothing
  task automatic apply_settings(logic [3:0] w, logic [3:0] h, logic [7:0] limit);
    logic [7:0] data [4];
    data[mep_pkg::CfgWidthLog2]  = {4'($urandom), w};
    data[mep_pkg::CfgHeightLog2] = {4'($urandom), h};
    data[mep_pkg::CfgMaxIter]    = limit;
    data[3]                      = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= data[i];
      @(posedge clk_i);
      sb.set_register(2'(i), data[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [3:0] w, logic [3:0] h, logic [7:0] limit, int count,
                           int idle_pct);
    apply_settings(w, h, limit);
    for (int i = 0; i < count; i++) begin
      send_pixel(12'($urandom), 12'($urandom), idle_pct);
    end
    wait_idle();
  endtask

  initial begin
    sb = new();
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    start      <= 1'b0;
    pixel_x_i  <= '0;
    pixel_y_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels at the reset settings, back to back
    foreach (DirectedPixels[i]) begin
      send_pixel(DirectedPixels[i][23:12], DirectedPixels[i][11:0], 0);
    end
    wait_idle();

    // random phases: sender idle 0, 76 or 6 percent of cycles; the receiver never stalls.
    // long limits are kept to few requests since in-set pixels run through every step
    run_phase(4'd8,  4'd8,  8'd64,  300, 0);
    run_phase(4'd4,  4'd3,  8'd32,  300, 76);
    run_phase(4'd12, 4'd12, 8'd255, 60,  6);
    run_phase(4'd1,  4'd1,  8'd1,   200, 0);
    // zero limit with size registers below and above their range
    run_phase(4'd0,  4'd15, 8'd0,   150, 76);
    run_phase(4'd13, 4'd0,  8'd20,  250, 6);
    run_phase(4'd6,  4'd10, 8'd100, 300, 0);
    run_phase(4'($urandom_range(1, 12)), 4'($urandom_range(1, 12)),
              8'($urandom_range(1, 48)), 250, 76);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
